// ===== hw/rtl/probe_interpolation_weights_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef PROBE_INTERPOLATION_WEIGHTS_CORE_DEFINES_SVH
`define PROBE_INTERPOLATION_WEIGHTS_CORE_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define PIW_ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define PIW_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== hw/rtl/piw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piw_pkg
// Shared constants and types of the probe interpolation weights block.
// ----------------------------------------------------------------------------
package piw_pkg;

   localparam int MaxProbesDefault = 64;
   localparam int CoordBitsDefault = 16;
   localparam int ResultLimit      = 64;
   localparam int IndexBits        = 6;
   localparam int WeightBits       = 17;
   localparam int CountBits        = 7;
   localparam int DistBits         = 34;
   // Ratio t of smallest distance over distance, Q30, never above 2^30.
   localparam int RatioBits        = 31;
   // u = t*t >> 30 fits in 31 bits; the sum of 64 fits in 37 bits.
   localparam int TermBits         = 31;
   localparam int SumBits          = 37;
   localparam logic [WeightBits-1:0] OneQ16 = 17'h10000;

   localparam logic [0:0] ReqWrite     = 1'b0;
   localparam logic [0:0] ModeNearest  = 1'b0;
   localparam logic [0:0] CsrModeIndex  = 1'b0;
   localparam logic [0:0] CsrCountIndex = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_DIST,
      ST_NEAR_OUT,
      ST_P1_READ,
      ST_P1_DIV,
      ST_P1_SQ,
      ST_P2_READ,
      ST_P2_DIV,
      ST_P2_SQ,
      ST_P2_NDIV,
      ST_OUT
   } state_type;

endpackage

// ===== hw/rtl/probe_interpolation_weights_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// probe_interpolation_weights_core
// Probe position table with nearest-probe and inverse-distance weights.
// ----------------------------------------------------------------------------
// Usage: a req_ transaction with req_type 0 writes one probe position into
// the table and yields no response. A query (req_type 1) reads entries 0 to
// n-1, n from the count register (0 counts as 1, capped at MAX_PROBES and
// at 64). Nearest mode returns one rsp_ transaction, with weight one and
// rsp_last, for the nearest probe. Inverse-distance mode walks the table
// three times: once for the minimum, once to sum the terms, once to
// normalize. Each probe of the second and third pass goes through the one
// shared radix-2 divider. One result leaves per probe, rsp_probe_index in
// order, with rsp_last on the final one. A query on a probe position skips
// the divider: after the first pass the nearest probe gets weight one and
// all others get zero. req_stall is high from acceptance until the last
// response is taken. A high rsp_stall holds the response; the sequencer
// waits in its output state until it is taken. Reset clears the sequencer
// and the registers (mode 0, count 1); the table is not cleared and must be
// written before it is queried.
// ----------------------------------------------------------------------------
module probe_interpolation_weights_core
   import piw_pkg::*;
#(
   parameter int MAX_PROBES = MaxProbesDefault,
   parameter int COORD_BITS = CoordBitsDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_type,
   input  logic [IndexBits-1:0]          req_probe_slot,
   input  logic signed [COORD_BITS-1:0]  req_coord_x,
   input  logic signed [COORD_BITS-1:0]  req_coord_y,
   input  logic signed [COORD_BITS-1:0]  req_coord_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [IndexBits-1:0]          rsp_probe_index,
   output logic [WeightBits-1:0]         rsp_weight,
   output logic                          rsp_last,
   input  logic                          csr_write,
   input  logic [0:0]                    csr_index,
   input  logic [CountBits-1:0]          csr_data
);

   localparam int AddrBits   = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
   localparam int DistShift  = (COORD_BITS > 16) ? COORD_BITS - 16 : 0;
   localparam int MagBits    = COORD_BITS + 1;
   localparam int LimitInt   = (MAX_PROBES < ResultLimit) ? MAX_PROBES : ResultLimit;
   localparam logic [CountBits-1:0] Limit = CountBits'(LimitInt);
   // Dividend widths: m*2^30 (64 bits) and u*2^16 (47 bits).
   localparam int DivBits    = 64;
   localparam int DivCntBits = 7;

   // Configuration.
   logic                 mode_ff;
   logic [CountBits-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= ModeNearest;
         count_ff <= CountBits'(1);
      end else if (csr_write) begin
         if (csr_index == CsrModeIndex) begin
            mode_ff <= csr_data[0];
         end else begin
            count_ff <= csr_data;
         end
      end
   end

   // Probe table memory with a registered read.
   logic [3*COORD_BITS-1:0] table_mem [MAX_PROBES];
   logic [3*COORD_BITS-1:0] rd_data_ff;
   logic [AddrBits-1:0]     rd_addr;

   // Sequencer registers.
   state_type            state_ff, state_in;
   logic [CountBits-1:0] n_ff, n_in;
   logic [CountBits-1:0] i_ff, i_in;
   logic signed [COORD_BITS-1:0] px_ff, py_ff, pz_ff;
   logic [DistBits-1:0]  d_ff, d_in;
   logic [DistBits-1:0]  m_ff, m_in;
   logic [IndexBits-1:0] best_ff, best_in;
   logic [SumBits-1:0]   sum_ff, sum_in;
   logic [TermBits-1:0]  u_ff, u_in;
   logic [1:0]           ax_ff, ax_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IndexBits-1:0] rsp_idx_ff, rsp_idx_in;
   logic [WeightBits-1:0] rsp_w_ff, rsp_w_in;
   logic                 rsp_last_ff, rsp_last_in;

   // Shared restoring divider: quotient bits shift into the dividend.
   logic [DivBits-1:0]    num_ff, num_in;
   logic [DivBits-1:0]    den_ff, den_in;
   logic [DivBits:0]      rem_ff, rem_in;
   logic [DivCntBits-1:0] dcnt_ff, dcnt_in;

   logic accept_req;
   assign accept_req = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (accept_req && req_type == ReqWrite &&
          32'(req_probe_slot) < 32'(MAX_PROBES)) begin
         table_mem[AddrBits'(req_probe_slot)] <= {req_coord_x, req_coord_y, req_coord_z};
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   // One axis term per cycle: the single squarer.
   logic signed [COORD_BITS-1:0] tab_c, pt_c;
   logic signed [MagBits-1:0]    diff;
   logic [MagBits-1:0]           mag;
   logic [16:0]                  mag_s;
   logic [DistBits-1:0]          sq;
   logic [DivBits:0]             rem_sh;
   logic [2*RatioBits-1:0]       tt;

   always_comb begin
      case (ax_ff)
         2'd0: begin
            tab_c = rd_data_ff[3*COORD_BITS-1 -: COORD_BITS];
            pt_c  = px_ff;
         end
         2'd1: begin
            tab_c = rd_data_ff[2*COORD_BITS-1 -: COORD_BITS];
            pt_c  = py_ff;
         end
         default: begin
            tab_c = rd_data_ff[COORD_BITS-1:0];
            pt_c  = pz_ff;
         end
      endcase
      diff  = MagBits'(tab_c) - MagBits'(pt_c);
      mag   = diff[MagBits-1] ? MagBits'(-diff) : diff;
      mag_s = 17'(mag >> DistShift);
      sq    = DistBits'(mag_s) * DistBits'(mag_s);
      rem_sh = {rem_ff[DivBits-1:0], num_ff[DivBits-1]};
      tt    = (2*RatioBits)'(num_ff[RatioBits-1:0]) * (2*RatioBits)'(num_ff[RatioBits-1:0]);
   end

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      i_in     = i_ff;
      d_in     = d_ff;
      m_in     = m_ff;
      best_in  = best_ff;
      sum_in   = sum_ff;
      u_in     = u_ff;
      ax_in    = ax_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      dcnt_in  = dcnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_idx_in   = rsp_idx_ff;
      rsp_w_in     = rsp_w_ff;
      rsp_last_in  = rsp_last_ff;
      rd_addr      = AddrBits'(i_ff);
      req_stall    = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            req_stall = rsp_valid_ff;
            i_in = '0;
            if (accept_req && req_type != ReqWrite) begin
               n_in = (count_ff == '0) ? CountBits'(1) :
                      (count_ff > Limit) ? Limit : count_ff;
               m_in = '1;
               best_in = '0;
               state_in = ST_READ;
            end
         end
         // First pass: read one entry, then sum its three squared axis terms.
         ST_READ: begin
            ax_in = 2'd0;
            d_in  = '0;
            state_in = ST_DIST;
         end
         ST_DIST: begin
            d_in  = d_ff + sq;
            ax_in = ax_ff + 2'd1;
            if (ax_ff == 2'd2) begin
               if (d_in < m_ff) begin
                  m_in    = d_in;
                  best_in = IndexBits'(i_ff);
               end
               i_in = i_ff + 1'b1;
               if (i_in == n_ff) begin
                  i_in = '0;
                  ax_in = 2'd0;
                  sum_in = '0;
                  state_in = (mode_ff == ModeNearest) ? ST_NEAR_OUT :
                             (m_in == '0) ? ST_OUT : ST_P1_READ;
               end else begin
                  state_in = ST_READ;
               end
               // Fetch the next entry so that it is ready in the next state.
               rd_addr = AddrBits'(i_in);
            end
         end
         ST_NEAR_OUT: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = best_ff;
               rsp_w_in     = OneQ16;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         // Second and third pass: recompute D, divide, square; the third pass then divides by the sum.
         ST_P1_READ, ST_P2_READ: begin
            if (ax_ff == 2'd3) begin
               ax_in = 2'd0;
               num_in = {m_ff, 30'd0};
               den_in = DivBits'(d_ff);
               rem_in = '0;
               dcnt_in = '0;
               state_in = (state_ff == ST_P1_READ) ? ST_P1_DIV : ST_P2_DIV;
            end else begin
               if (ax_ff == 2'd0) d_in = sq;
               else d_in = d_ff + sq;
               ax_in = ax_ff + 2'd1;
            end
         end
         ST_P1_DIV, ST_P2_DIV, ST_P2_NDIV: begin
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_in = rem_sh - {1'b0, den_ff};
               num_in = {num_ff[DivBits-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               num_in = {num_ff[DivBits-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DivCntBits'(DivBits-1)) begin
               case (state_ff)
                  ST_P1_DIV: state_in = ST_P1_SQ;
                  ST_P2_DIV: state_in = ST_P2_SQ;
                  default:   state_in = ST_OUT;
               endcase
            end
         end
         ST_P1_SQ, ST_P2_SQ: begin
            u_in = TermBits'(tt >> 30);
            if (state_ff == ST_P1_SQ) begin
               sum_in = sum_ff + SumBits'(u_in);
               i_in = i_ff + 1'b1;
               if (i_in == n_ff) begin
                  i_in = '0;
               end
               rd_addr = AddrBits'(i_in);
               state_in = (i_in == '0) ? ST_P2_READ : ST_P1_READ;
            end else begin
               num_in = DivBits'({u_in, 16'd0}) << (DivBits - TermBits - 16);
               den_in = DivBits'(sum_ff);
               rem_in = '0;
               dcnt_in = DivCntBits'(DivBits - TermBits - 16);
               state_in = ST_P2_NDIV;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = IndexBits'(i_ff);
               if (m_ff == '0) begin
                  rsp_w_in = (IndexBits'(i_ff) == best_ff) ? OneQ16 : '0;
               end else begin
                  rsp_w_in = WeightBits'(num_ff);
               end
               rsp_last_in = (i_ff + 1'b1 == n_ff);
               i_in = i_ff + 1'b1;
               rd_addr = AddrBits'(i_in);
               if (i_in == n_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  ax_in = 2'd0;
                  state_in = (m_ff == '0) ? ST_OUT : ST_P2_READ;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // The read pass states address the current entry so that the registered read has it ready for squaring.
      if (state_ff == ST_P1_READ || state_ff == ST_P2_READ || state_ff == ST_READ ||
          state_ff == ST_DIST) begin
         if (!(state_ff == ST_DIST && ax_ff == 2'd2)) rd_addr = AddrBits'(i_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ax_ff        <= 2'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ax_ff        <= ax_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_req) begin
         px_ff <= req_coord_x;
         py_ff <= req_coord_y;
         pz_ff <= req_coord_z;
      end
      n_ff    <= n_in;
      i_ff    <= i_in;
      d_ff    <= d_in;
      m_ff    <= m_in;
      best_ff <= best_in;
      sum_ff  <= sum_in;
      u_ff    <= u_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      dcnt_ff <= dcnt_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_w_ff    <= rsp_w_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_probe_index = rsp_idx_ff;
   assign rsp_weight      = rsp_w_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// ===== hw/rtl/piw_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piw_checker
// Port-level checks on the probe interpolation weights block.
// ----------------------------------------------------------------------------
`include "probe_interpolation_weights_core_defines.svh"
module piw_checker
   import piw_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [WeightBits-1:0] rsp_weight,
   input logic                  rsp_last
);

   logic rsp_held;
   logic req_take;
   assign rsp_held = rsp_valid && rsp_stall;
   assign req_take = req_valid && !req_stall;

   // A stalled response holds.
   `PIW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_weight), "stalled response changed")
   // Weights never exceed one.
   `PIW_ASSERT_IMPL(a_weight_max, clock, reset, rsp_valid, rsp_weight <= OneQ16, "weight above 1.0")
   // No new request is taken while a response other than the last is waiting.
   `PIW_ASSERT_IMPL(a_no_overlap, clock, reset, rsp_valid && !rsp_last, req_stall, "taken mid query")
   // A request is only accepted with no response outstanding.
   `PIW_ASSERT_IMPL(a_accept_idle, clock, reset, req_take, !rsp_valid, "accepted while busy")

endmodule

bind probe_interpolation_weights_core piw_checker u_piw_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_weight(rsp_weight),
   .rsp_last(rsp_last)
);
